[rtl/core/assert_macros.svh]
// Assertion macros shared by the cache RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define CHK_ALWAYS(name, clk, rst, expr) \
  name: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("invariant violated");

// Property whose consequent must hold in the cycle after the antecedent.
`define CHK_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check violated");

`endif

[rtl/core/lwbc_pkg.sv]
// Types, codes and sizes of the block cache tag controller.
package lwbc_pkg;

  localparam int SLOTS        = 16;
  localparam int CLUSTER_BITS = 28;
  localparam int SLOT_BITS    = $clog2(SLOTS);
  localparam int COUNT_BITS   = $clog2(SLOTS + 1);
  localparam int STAMP_BITS   = 32;
  localparam int CMD_BITS     = 3;
  localparam int KIND_BITS    = 2;

  localparam logic [CMD_BITS-1:0] CMD_READ       = 3'd0;
  localparam logic [CMD_BITS-1:0] CMD_WRITE      = 3'd1;
  localparam logic [CMD_BITS-1:0] CMD_FLUSH_ONE  = 3'd2;
  localparam logic [CMD_BITS-1:0] CMD_FLUSH_ALL  = 3'd3;
  localparam logic [CMD_BITS-1:0] CMD_INVALIDATE = 3'd4;

  localparam logic [KIND_BITS-1:0] KIND_DONE      = 2'd0;
  localparam logic [KIND_BITS-1:0] KIND_LOAD      = 2'd1;
  localparam logic [KIND_BITS-1:0] KIND_WRITEBACK = 2'd2;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_START,
    OP_SCAN,
    OP_EVICT,
    OP_FILL,
    OP_FLUSH_ONE,
    OP_FLUSH_STEP,
    OP_FINISH
  } dp_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_ROUTE,
    ST_EVICT,
    ST_FILL,
    ST_FLUSH_ONE,
    ST_FLUSH_ALL,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [CMD_BITS-1:0] cmd;
    logic                scan_last;
    logic                hit;
    logic                need_evict;
    logic                sel_dirty;
    logic                emit_ok;
  } dp_status_t;

  typedef struct packed {
    logic [KIND_BITS-1:0]    kind;
    logic [SLOT_BITS-1:0]    slot;
    logic [CLUSTER_BITS-1:0] target_cluster;
    logic                    hit;
    logic                    last;
    logic [COUNT_BITS-1:0]   used_count;
    logic [COUNT_BITS-1:0]   dirty_count;
  } result_t;

endpackage

[rtl/core/lwbc_cmd_if.sv]
// Command channel: one command code and one cluster number per transaction.
interface lwbc_cmd_if;
  logic                              valid;
  logic                              ready;
  logic [lwbc_pkg::CMD_BITS-1:0]     command;
  logic [lwbc_pkg::CLUSTER_BITS-1:0] cluster;

  modport source (output valid, output command, output cluster, input ready);
  modport sink   (input valid, input command, input cluster, output ready);
endinterface

[rtl/core/lwbc_rsp_if.sv]
// Result channel: one disk request or completion per transaction.
interface lwbc_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [lwbc_pkg::KIND_BITS-1:0]    kind;
  logic [lwbc_pkg::SLOT_BITS-1:0]    slot;
  logic [lwbc_pkg::CLUSTER_BITS-1:0] target_cluster;
  logic                              hit;
  logic                              last;
  logic [lwbc_pkg::COUNT_BITS-1:0]   used_count;
  logic [lwbc_pkg::COUNT_BITS-1:0]   dirty_count;

  modport source (output valid, output kind, output slot, output target_cluster,
                  output hit, output last, output used_count, output dirty_count,
                  input ready);
  modport sink   (input valid, input kind, input slot, input target_cluster,
                  input hit, input last, input used_count, input dirty_count,
                  output ready);
endinterface

[rtl/core/lwbc_ctrl.sv]
// Command sequencer of the block cache: steps scan, evict, fill, flush and finish.
module lwbc_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  input  logic [lwbc_pkg::CMD_BITS-1:0] req_command,
  input  lwbc_pkg::dp_status_t          status,
  output logic                          req_ready,
  output lwbc_pkg::dp_op_t              op
);

  lwbc_pkg::state_t state;
  lwbc_pkg::state_t state_next;
  logic             is_rw;

  assign is_rw = (status.cmd == lwbc_pkg::CMD_READ) ||
                 (status.cmd == lwbc_pkg::CMD_WRITE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lwbc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      lwbc_pkg::ST_IDLE: begin
        if (req_valid) begin
          if (req_command == lwbc_pkg::CMD_FLUSH_ALL) begin
            state_next = lwbc_pkg::ST_FLUSH_ALL;
          end else if (req_command <= lwbc_pkg::CMD_INVALIDATE) begin
            state_next = lwbc_pkg::ST_SCAN;
          end else begin
            state_next = lwbc_pkg::ST_FINISH;
          end
        end
      end
      lwbc_pkg::ST_SCAN: begin
        if (status.scan_last) state_next = lwbc_pkg::ST_ROUTE;
      end
      lwbc_pkg::ST_ROUTE: begin
        if (is_rw && !status.hit) begin
          state_next = status.need_evict ? lwbc_pkg::ST_EVICT : lwbc_pkg::ST_FILL;
        end else if ((status.cmd == lwbc_pkg::CMD_FLUSH_ONE) && status.hit &&
                     status.sel_dirty) begin
          state_next = lwbc_pkg::ST_FLUSH_ONE;
        end else begin
          state_next = lwbc_pkg::ST_FINISH;
        end
      end
      lwbc_pkg::ST_EVICT: begin
        if (status.emit_ok) state_next = lwbc_pkg::ST_FILL;
      end
      lwbc_pkg::ST_FILL: begin
        if (status.emit_ok) state_next = lwbc_pkg::ST_FINISH;
      end
      lwbc_pkg::ST_FLUSH_ONE: begin
        if (status.emit_ok) state_next = lwbc_pkg::ST_FINISH;
      end
      lwbc_pkg::ST_FLUSH_ALL: begin
        if (status.emit_ok && status.scan_last) state_next = lwbc_pkg::ST_FINISH;
      end
      lwbc_pkg::ST_FINISH: begin
        if (status.emit_ok) state_next = lwbc_pkg::ST_IDLE;
      end
      default: begin
        state_next = lwbc_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    req_ready = 1'b0;
    op        = lwbc_pkg::OP_NONE;
    case (state)
      lwbc_pkg::ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) op = lwbc_pkg::OP_START;
      end
      lwbc_pkg::ST_SCAN: begin
        op = lwbc_pkg::OP_SCAN;
      end
      lwbc_pkg::ST_EVICT: begin
        if (status.emit_ok) op = lwbc_pkg::OP_EVICT;
      end
      lwbc_pkg::ST_FILL: begin
        if (status.emit_ok) op = lwbc_pkg::OP_FILL;
      end
      lwbc_pkg::ST_FLUSH_ONE: begin
        if (status.emit_ok) op = lwbc_pkg::OP_FLUSH_ONE;
      end
      lwbc_pkg::ST_FLUSH_ALL: begin
        if (status.emit_ok) op = lwbc_pkg::OP_FLUSH_STEP;
      end
      lwbc_pkg::ST_FINISH: begin
        if (status.emit_ok) op = lwbc_pkg::OP_FINISH;
      end
      default: begin
        op = lwbc_pkg::OP_NONE;
      end
    endcase
  end

endmodule

[rtl/core/lwbc_dpath.sv]
// Slot state, scan registers, occupancy counters and result register.
`include "assert_macros.svh"

module lwbc_dpath (
  input  logic                              clk,
  input  logic                              rst,
  input  lwbc_pkg::dp_op_t                  op,
  input  logic [lwbc_pkg::CMD_BITS-1:0]     req_command,
  input  logic [lwbc_pkg::CLUSTER_BITS-1:0] req_cluster,
  input  logic                              rsp_ready,
  output logic                              rsp_valid,
  output lwbc_pkg::result_t                 result,
  output lwbc_pkg::dp_status_t              status
);

  logic [lwbc_pkg::CLUSTER_BITS-1:0] tag [lwbc_pkg::SLOTS];
  logic [lwbc_pkg::STAMP_BITS-1:0]   stamp [lwbc_pkg::SLOTS];
  logic [lwbc_pkg::SLOTS-1:0]        valid;
  logic [lwbc_pkg::SLOTS-1:0]        dirty;
  logic [lwbc_pkg::STAMP_BITS-1:0]   access_clock;
  logic [lwbc_pkg::COUNT_BITS-1:0]   used_count;
  logic [lwbc_pkg::COUNT_BITS-1:0]   dirty_count;
  logic [lwbc_pkg::COUNT_BITS-1:0]   used_next;
  logic [lwbc_pkg::COUNT_BITS-1:0]   dirty_next;

  logic [lwbc_pkg::CMD_BITS-1:0]     cmd;
  logic [lwbc_pkg::CLUSTER_BITS-1:0] cluster;
  logic [lwbc_pkg::SLOT_BITS-1:0]    idx;
  logic                              match_found;
  logic [lwbc_pkg::SLOT_BITS-1:0]    match_idx;
  logic                              free_found;
  logic [lwbc_pkg::SLOT_BITS-1:0]    free_idx;
  logic [lwbc_pkg::SLOT_BITS-1:0]    victim_idx;
  logic [lwbc_pkg::CLUSTER_BITS-1:0] victim_tag;
  logic [lwbc_pkg::STAMP_BITS-1:0]   oldest;

  logic [lwbc_pkg::SLOT_BITS-1:0]    sel;
  logic                              is_rw;
  logic                              emit_ok;
  logic                              emit;
  lwbc_pkg::result_t                 result_next;

  assign sel = match_found ? match_idx : (free_found ? free_idx : victim_idx);
  assign is_rw = (cmd == lwbc_pkg::CMD_READ) || (cmd == lwbc_pkg::CMD_WRITE);
  assign emit_ok = !rsp_valid || rsp_ready;

  assign status.cmd        = cmd;
  assign status.scan_last  = (idx == lwbc_pkg::SLOT_BITS'(lwbc_pkg::SLOTS - 1));
  assign status.hit        = match_found;
  assign status.need_evict = !free_found && dirty[victim_idx];
  assign status.sel_dirty  = dirty[sel];
  assign status.emit_ok    = emit_ok;

  // Result fields and occupancy after the operation of this cycle.
  always_comb begin
    emit                       = 1'b0;
    used_next                  = used_count;
    dirty_next                 = dirty_count;
    result_next.kind           = lwbc_pkg::KIND_DONE;
    result_next.slot           = sel;
    result_next.target_cluster = cluster;
    result_next.hit            = 1'b0;
    result_next.last           = 1'b0;
    case (op)
      lwbc_pkg::OP_EVICT: begin
        emit                       = 1'b1;
        used_next                  = used_count - lwbc_pkg::COUNT_BITS'(1);
        dirty_next                 = dirty_count - lwbc_pkg::COUNT_BITS'(1);
        result_next.kind           = lwbc_pkg::KIND_WRITEBACK;
        result_next.slot           = victim_idx;
        result_next.target_cluster = victim_tag;
      end
      lwbc_pkg::OP_FILL: begin
        emit             = (cmd == lwbc_pkg::CMD_READ);
        result_next.kind = lwbc_pkg::KIND_LOAD;
        if (!valid[sel]) used_next = used_count + lwbc_pkg::COUNT_BITS'(1);
      end
      lwbc_pkg::OP_FLUSH_ONE: begin
        emit             = 1'b1;
        dirty_next       = dirty_count - lwbc_pkg::COUNT_BITS'(1);
        result_next.kind = lwbc_pkg::KIND_WRITEBACK;
        result_next.hit  = 1'b1;
      end
      lwbc_pkg::OP_FLUSH_STEP: begin
        result_next.kind           = lwbc_pkg::KIND_WRITEBACK;
        result_next.slot           = idx;
        result_next.target_cluster = tag[idx];
        if (valid[idx] && dirty[idx]) begin
          emit       = 1'b1;
          dirty_next = dirty_count - lwbc_pkg::COUNT_BITS'(1);
        end
      end
      lwbc_pkg::OP_FINISH: begin
        emit             = 1'b1;
        result_next.hit  = match_found;
        result_next.last = 1'b1;
        result_next.slot = (is_rw || match_found) ? sel : '0;
        if (cmd == lwbc_pkg::CMD_FLUSH_ALL) result_next.target_cluster = '0;
        if ((cmd == lwbc_pkg::CMD_WRITE) && !dirty[sel]) begin
          dirty_next = dirty_count + lwbc_pkg::COUNT_BITS'(1);
        end
        if ((cmd == lwbc_pkg::CMD_INVALIDATE) && match_found) begin
          used_next = used_count - lwbc_pkg::COUNT_BITS'(1);
          if (dirty[sel]) dirty_next = dirty_count - lwbc_pkg::COUNT_BITS'(1);
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
    result_next.used_count  = used_next;
    result_next.dirty_count = dirty_next;
  end

  // Control state: slot flags, stamps, access clock, counters, scan pointer.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid        <= '0;
      dirty        <= '0;
      access_clock <= '0;
      used_count   <= '0;
      dirty_count  <= '0;
      rsp_valid    <= 1'b0;
      cmd          <= lwbc_pkg::CMD_READ;
      idx          <= '0;
      match_found  <= 1'b0;
      free_found   <= 1'b0;
      for (int i = 0; i < lwbc_pkg::SLOTS; i++) begin
        stamp[i] <= '0;
      end
    end else begin
      used_count  <= used_next;
      dirty_count <= dirty_next;
      if (emit) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (op)
        lwbc_pkg::OP_START: begin
          cmd         <= req_command;
          idx         <= '0;
          match_found <= 1'b0;
          free_found  <= 1'b0;
        end
        lwbc_pkg::OP_SCAN: begin
          if (valid[idx] && (tag[idx] == cluster) && !match_found) match_found <= 1'b1;
          if (!valid[idx] && !free_found) free_found <= 1'b1;
          idx <= idx + lwbc_pkg::SLOT_BITS'(1);
        end
        lwbc_pkg::OP_EVICT: begin
          valid[victim_idx] <= 1'b0;
          dirty[victim_idx] <= 1'b0;
        end
        lwbc_pkg::OP_FILL: begin
          valid[sel] <= 1'b1;
          dirty[sel] <= 1'b0;
        end
        lwbc_pkg::OP_FLUSH_ONE: begin
          dirty[sel] <= 1'b0;
        end
        lwbc_pkg::OP_FLUSH_STEP: begin
          if (valid[idx]) dirty[idx] <= 1'b0;
          idx <= idx + lwbc_pkg::SLOT_BITS'(1);
        end
        lwbc_pkg::OP_FINISH: begin
          if (is_rw) begin
            access_clock <= access_clock + lwbc_pkg::STAMP_BITS'(1);
            stamp[sel]   <= access_clock + lwbc_pkg::STAMP_BITS'(1);
            if (cmd == lwbc_pkg::CMD_WRITE) dirty[sel] <= 1'b1;
          end
          if ((cmd == lwbc_pkg::CMD_INVALIDATE) && match_found) begin
            valid[sel] <= 1'b0;
            dirty[sel] <= 1'b0;
          end
        end
        default: begin
          cmd <= cmd;
        end
      endcase
    end
  end

  // Payload: tags, scan results and the result register.
  always_ff @(posedge clk) begin
    if (emit) result <= result_next;
    case (op)
      lwbc_pkg::OP_START: begin
        cluster <= req_cluster;
      end
      lwbc_pkg::OP_SCAN: begin
        if (valid[idx] && (tag[idx] == cluster) && !match_found) match_idx <= idx;
        if (!valid[idx] && !free_found) free_idx <= idx;
        if ((idx == '0) || (stamp[idx] < oldest)) begin
          oldest     <= stamp[idx];
          victim_idx <= idx;
          victim_tag <= tag[idx];
        end
      end
      lwbc_pkg::OP_FILL: begin
        tag[sel] <= cluster;
      end
      lwbc_pkg::OP_FINISH: begin
        if ((cmd == lwbc_pkg::CMD_INVALIDATE) && match_found) tag[sel] <= '0;
      end
      default: begin
        oldest <= oldest;
      end
    endcase
  end

  `CHK_ALWAYS(a_used_matches_valid, clk, rst, used_count == lwbc_pkg::COUNT_BITS'($countones(valid)))
  `CHK_ALWAYS(a_dirty_matches_flags, clk, rst, dirty_count == lwbc_pkg::COUNT_BITS'($countones(dirty)))
  `CHK_ALWAYS(a_dirty_implies_valid, clk, rst, (dirty & ~valid) == '0)
  `CHK_NEXT(a_fill_sets_valid, clk, rst, op == lwbc_pkg::OP_FILL, valid[$past(sel)])

endmodule

[rtl/core/lru_write_back_block_cache.sv]
// Sequence: a command is taken in the idle state; all but flush all and an undefined
//   command then scan every slot, one slot per cycle, and pass a routing step; each
//   following result is issued when the result register is free. Flush all walks every
//   slot, one slot per cycle while the result register is free, and an undefined
//   command goes straight to its finish; a new command waits until the previous one ends.
// Reset: synchronous rst frees every slot and clears stamps, access clock and counters;
//   no clearing pass follows.
module lru_write_back_block_cache (
  input logic        clk,
  input logic        rst,
  lwbc_cmd_if.sink   req,
  lwbc_rsp_if.source rsp
);

  // Commands from the sequencer, status back from the datapath.
  lwbc_pkg::dp_op_t     op;
  lwbc_pkg::dp_status_t status;
  lwbc_pkg::result_t    result;

  // The sequencer owns the command handshake: a new transaction is taken only
  // in its idle state, even while the previous result still waits downstream.
  lwbc_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req.valid),
    .req_command (req.command),
    .status      (status),
    .req_ready   (req.ready),
    .op          (op)
  );

  // The datapath holds slot tags, flags and stamps, the scan registers and the
  // result register that parts the result channel from the command side.
  lwbc_dpath u_dpath (
    .clk         (clk),
    .rst         (rst),
    .op          (op),
    .req_command (req.command),
    .req_cluster (req.cluster),
    .rsp_ready   (rsp.ready),
    .rsp_valid   (rsp.valid),
    .result      (result),
    .status      (status)
  );

  // Drive the result channel straight from the registered result.
  assign rsp.kind           = result.kind;
  assign rsp.slot           = result.slot;
  assign rsp.target_cluster = result.target_cluster;
  assign rsp.hit            = result.hit;
  assign rsp.last           = result.last;
  assign rsp.used_count     = result.used_count;
  assign rsp.dirty_count    = result.dirty_count;

endmodule
